@@ sv/rtdc_pkg.sv @@
// Shared types and constants for the rain tip debounce counter.
package rtdc_pkg;

    // Field and register widths.
    localparam int TIME_W   = 32;
    localparam int WIN_W    = 16;
    localparam int MINUTE_W = 16;
    localparam int COUNT_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REPEAT_WINDOW = 2'd0,
        CFG_GLITCH_WINDOW = 2'd1,
        CFG_MINUTE_PERIOD = 2'd2,
        CFG_PIN_ENABLE    = 2'd3
    } cfg_index_t;

    // Register values after reset.
    localparam logic [WIN_W-1:0]  REPEAT_WINDOW_RST = 16'd500;
    localparam logic [WIN_W-1:0]  GLITCH_WINDOW_RST = 16'd10;
    localparam logic [TIME_W-1:0] MINUTE_PERIOD_RST = 32'd60000;

    // Saturation limits of the tip counters.
    localparam logic [MINUTE_W-1:0] MINUTE_SAT = '1;
    localparam logic [COUNT_W-1:0]  COUNT_SAT  = '1;

endpackage

@@ sv/rain_tip_debounce_counter_unit.sv @@
// Rain tip debounce counter: millisecond tick in, tip and minute report out.
//
//  Channel | Direction | Signals                                      | Beat
//  --------+-----------+----------------------------------------------+-----------------------
//  in      | input     | in_valid/in_ready, pin_level, clear_day,     | one millisecond tick
//          |           | take_since                                   |
//  out     | output    | out_valid/out_ready, tip_confirmed,          | one report per tick
//          |           | tip_rejected, minute_valid, minute_tips,     |
//          |           | day_tips, since_tips                         |
//  cfg     | input     | cfg_wr_en, cfg_addr, cfg_wdata               | one register write
//
// A tick beat is held in the input register; its report is written to the output
// register when that register is free, and one beat is taken every cycle while
// the output is not stalled. The rate is set by the update of the timing and count
// state, which the next tick reads. Reset loads the register defaults and clears
// all counters and timers. When the output register holds an untaken beat, the
// input register holds its beat and in_ready drops until out_ready returns.
module rain_tip_debounce_counter_unit
    import rtdc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  pin_level,
    input  logic                  clear_day,
    input  logic                  take_since,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  tip_confirmed,
    output logic                  tip_rejected,
    output logic                  minute_valid,
    output logic [MINUTE_W-1:0]   minute_tips,
    output logic [COUNT_W-1:0]    day_tips,
    output logic [COUNT_W-1:0]    since_tips
);

    // Configuration registers.
    logic [WIN_W-1:0]  repeat_window_reg;
    logic [WIN_W-1:0]  glitch_window_reg;
    logic [TIME_W-1:0] minute_period_reg;
    logic              pin_enabled_reg;

    // Input register.
    logic in_valid_reg;
    logic pin_level_reg;
    logic clear_day_reg;
    logic take_since_reg;

    // Tick state.
    logic [TIME_W-1:0]   now_ms_reg;
    logic                prev_level_reg;
    logic [TIME_W-1:0]   last_edge_ms_reg;
    logic [TIME_W-1:0]   pending_ms_reg;
    logic                pending_flag_reg;
    logic [TIME_W-1:0]   minute_start_ms_reg;
    logic [MINUTE_W-1:0] minute_count_reg;
    logic [COUNT_W-1:0]  day_count_reg;
    logic [COUNT_W-1:0]  since_count_reg;

    // Output register.
    logic                out_valid_reg;
    logic                tip_confirmed_reg;
    logic                tip_rejected_reg;
    logic                minute_valid_reg;
    logic [MINUTE_W-1:0] minute_tips_reg;
    logic [COUNT_W-1:0]  day_tips_reg;
    logic [COUNT_W-1:0]  since_tips_reg;

    // Next values of the tick state and the report.
    logic                pending_flag_next;
    logic [TIME_W-1:0]   minute_start_ms_next;
    logic [MINUTE_W-1:0] minute_count_next;
    logic [COUNT_W-1:0]  day_count_next;
    logic [COUNT_W-1:0]  since_count_next;
    logic [MINUTE_W-1:0] minute_tips_next;

    // Handshake and datapath intermediates.
    logic                out_free;
    logic                fire;
    logic [TIME_W-1:0]   since_edge;
    logic [TIME_W-1:0]   since_pending;
    logic [TIME_W-1:0]   since_minute;
    logic                falling_edge;
    logic                edge_taken;
    logic                do_check;
    logic                confirm;
    logic                reject;
    logic                minute_close;
    logic [MINUTE_W-1:0] minute_inc;
    logic [COUNT_W-1:0]  day_inc;
    logic [COUNT_W-1:0]  since_inc;

    // The output register frees up when it is empty or being taken.
    assign out_free = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || fire;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_window_reg <= REPEAT_WINDOW_RST;
            glitch_window_reg <= GLITCH_WINDOW_RST;
            minute_period_reg <= MINUTE_PERIOD_RST;
            pin_enabled_reg   <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_REPEAT_WINDOW: repeat_window_reg <= cfg_wdata[WIN_W-1:0];
                CFG_GLITCH_WINDOW: glitch_window_reg <= cfg_wdata[WIN_W-1:0];
                CFG_MINUTE_PERIOD: minute_period_reg <= cfg_wdata[TIME_W-1:0];
                CFG_PIN_ENABLE:    pin_enabled_reg   <= cfg_wdata[0];
            endcase
        end
    end

    // Input register: takes a beat whenever it is empty or being drained.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pin_level_reg  <= pin_level;
            clear_day_reg  <= clear_day;
            take_since_reg <= take_since;
        end
    end

    // Elapsed times, all modulo 2^32.
    assign since_edge    = now_ms_reg - last_edge_ms_reg;
    assign since_pending = now_ms_reg - pending_ms_reg;
    assign since_minute  = now_ms_reg - minute_start_ms_reg;

    // Edge detection and the glitch check. A candidate taken this tick has
    // zero elapsed time, so it is checked at once only with a zero window.
    always_comb
    begin
        falling_edge = pin_enabled_reg && prev_level_reg && !pin_level_reg;
        edge_taken   = falling_edge &&
                       (since_edge >= {{(TIME_W-WIN_W){1'b0}}, repeat_window_reg});
        if (edge_taken)
        begin
            do_check = (glitch_window_reg == '0);
        end
        else
        begin
            do_check = pin_enabled_reg && pending_flag_reg &&
                       (since_pending >= {{(TIME_W-WIN_W){1'b0}}, glitch_window_reg});
        end
        confirm = do_check && !pin_level_reg;
        reject  = do_check && pin_level_reg;
        pending_flag_next = do_check ? 1'b0 : (edge_taken || pending_flag_reg);
    end

    // Saturating counts, the minute close and the clear requests.
    always_comb
    begin
        minute_inc = minute_count_reg;
        day_inc    = day_count_reg;
        since_inc  = since_count_reg;
        if (confirm)
        begin
            if (minute_count_reg != MINUTE_SAT)
            begin
                minute_inc = minute_count_reg + 1'b1;
            end
            if (day_count_reg != COUNT_SAT)
            begin
                day_inc = day_count_reg + 1'b1;
            end
            if (since_count_reg != COUNT_SAT)
            begin
                since_inc = since_count_reg + 1'b1;
            end
        end

        minute_close = (since_minute >= minute_period_reg);
        if (minute_close)
        begin
            minute_start_ms_next = minute_start_ms_reg + minute_period_reg;
            minute_tips_next     = minute_inc;
            minute_count_next    = '0;
        end
        else
        begin
            minute_start_ms_next = minute_start_ms_reg;
            minute_tips_next     = '0;
            minute_count_next    = minute_inc;
        end

        day_count_next   = clear_day_reg  ? '0 : day_inc;
        since_count_next = take_since_reg ? '0 : since_inc;
    end

    // Tick state update, one tick per processed beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_ms_reg          <= '0;
            prev_level_reg      <= 1'b1;
            last_edge_ms_reg    <= '0;
            pending_ms_reg      <= '0;
            pending_flag_reg    <= 1'b0;
            minute_start_ms_reg <= '0;
            minute_count_reg    <= '0;
            day_count_reg       <= '0;
            since_count_reg     <= '0;
        end
        else if (fire)
        begin
            now_ms_reg     <= now_ms_reg + 1'b1;
            prev_level_reg <= pin_level_reg;
            if (edge_taken)
            begin
                last_edge_ms_reg <= now_ms_reg;
                pending_ms_reg   <= now_ms_reg;
            end
            pending_flag_reg    <= pending_flag_next;
            minute_start_ms_reg <= minute_start_ms_next;
            minute_count_reg    <= minute_count_next;
            day_count_reg       <= day_count_next;
            since_count_reg     <= since_count_next;
        end
    end

    // Output register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            tip_confirmed_reg <= confirm;
            tip_rejected_reg  <= reject;
            minute_valid_reg  <= minute_close;
            minute_tips_reg   <= minute_tips_next;
            day_tips_reg      <= day_inc;
            since_tips_reg    <= since_inc;
        end
    end

    assign out_valid     = out_valid_reg;
    assign tip_confirmed = tip_confirmed_reg;
    assign tip_rejected  = tip_rejected_reg;
    assign minute_valid  = minute_valid_reg;
    assign minute_tips   = minute_tips_reg;
    assign day_tips      = day_tips_reg;
    assign since_tips    = since_tips_reg;

`ifndef ASSERT_OFF
    // A checked candidate is gone after the tick.
    a_check_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        fire && do_check |=> !pending_flag_reg)
        else $error("pending candidate survived its check");

    // A processed tick always leaves a report in the output register.
    a_fire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed tick left no report");

    // A report never both confirms and rejects.
    a_confirm_reject_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(tip_confirmed_reg && tip_rejected_reg))
        else $error("tip confirmed and rejected in one report");

    // Minute tips are zero unless a minute closed.
    a_minute_tips_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !minute_valid_reg |-> minute_tips_reg == '0)
        else $error("minute tips reported without a minute close");
`endif

endmodule

@@ bench/rtdc_checker.sv @@
// Checker for the rain tip debounce counter: predicts each tick report and compares it.
`timescale 1ns / 1ps

module rtdc_checker
    import rtdc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic                  pin_level,
    input  logic                  clear_day,
    input  logic                  take_since,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic                  tip_confirmed,
    input  logic                  tip_rejected,
    input  logic                  minute_valid,
    input  logic [MINUTE_W-1:0]   minute_tips,
    input  logic [COUNT_W-1:0]    day_tips,
    input  logic [COUNT_W-1:0]    since_tips,
    output int                    fail_count,
    output int                    reports_due
);

    typedef struct packed {
        logic                confirmed;
        logic                rejected;
        logic                minute_closed;
        logic [MINUTE_W-1:0] minute_total;
        logic [COUNT_W-1:0]  day_total;
        logic [COUNT_W-1:0]  since_total;
    } tick_report_t;

    // Local copy of the configuration registers.
    logic [WIN_W-1:0]  repeat_win;
    logic [WIN_W-1:0]  glitch_win;
    logic [TIME_W-1:0] period_len;
    logic              pin_on;

    // Local copy of the timing and count state.
    logic [TIME_W-1:0]   tick_ms;
    logic                prev_pin;
    logic [TIME_W-1:0]   last_cand_ms;
    logic [TIME_W-1:0]   cand_ms;
    logic                cand_open;
    logic [TIME_W-1:0]   period_start_ms;
    logic [MINUTE_W-1:0] period_tips;
    logic [COUNT_W-1:0]  day_count;
    logic [COUNT_W-1:0]  since_count;

    tick_report_t report_q[$];
    int           mismatches;

    // Advance the gauge by one millisecond tick and return the report it produces.
    function automatic tick_report_t predict_tick(input logic lvl, input logic clr_day,
                                                  input logic take);
        tick_report_t rpt;
        logic [TIME_W-1:0] since_cand;
        logic [TIME_W-1:0] since_check;
        logic [TIME_W-1:0] since_period;
        rpt = '0;

        // A falling edge outside the repeat window opens a candidate.
        since_cand = tick_ms - last_cand_ms;
        if (pin_on && prev_pin && !lvl && since_cand >= TIME_W'(repeat_win))
        begin
            last_cand_ms = tick_ms;
            cand_ms      = tick_ms;
            cand_open    = 1'b1;
        end
        prev_pin = lvl;

        // After the glitch window the pin level decides the candidate.
        since_check = tick_ms - cand_ms;
        if (pin_on && cand_open && since_check >= TIME_W'(glitch_win))
        begin
            cand_open = 1'b0;
            if (!lvl)
            begin
                rpt.confirmed = 1'b1;
                if (period_tips != MINUTE_SAT) period_tips++;
                if (day_count != COUNT_SAT) day_count++;
                if (since_count != COUNT_SAT) since_count++;
            end
            else
            begin
                rpt.rejected = 1'b1;
            end
        end

        // Close the minute period once it has run out.
        since_period = tick_ms - period_start_ms;
        if (since_period >= period_len)
        begin
            period_start_ms   = period_start_ms + period_len;
            rpt.minute_closed = 1'b1;
            rpt.minute_total  = period_tips;
            period_tips       = '0;
        end

        rpt.day_total   = day_count;
        rpt.since_total = since_count;
        if (clr_day) day_count = '0;
        if (take) since_count = '0;
        tick_ms = tick_ms + 1'b1;
        return rpt;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            mismatches++;
        end
    endtask

    // Follow register writes, predict each tick beat and check each report beat.
    always @(posedge clk or negedge rst_n)
    begin
        tick_report_t want;
        if (!rst_n)
        begin
            repeat_win      = REPEAT_WINDOW_RST;
            glitch_win      = GLITCH_WINDOW_RST;
            period_len      = MINUTE_PERIOD_RST;
            pin_on          = 1'b1;
            tick_ms         = '0;
            prev_pin        = 1'b1;
            last_cand_ms    = '0;
            cand_ms         = '0;
            cand_open       = 1'b0;
            period_start_ms = '0;
            period_tips     = '0;
            day_count       = '0;
            since_count     = '0;
            report_q.delete();
            mismatches      = 0;
            fail_count  <= 0;
            reports_due <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index_t'(cfg_addr))
                    CFG_REPEAT_WINDOW: repeat_win = cfg_wdata[WIN_W-1:0];
                    CFG_GLITCH_WINDOW: glitch_win = cfg_wdata[WIN_W-1:0];
                    CFG_MINUTE_PERIOD: period_len = cfg_wdata[TIME_W-1:0];
                    CFG_PIN_ENABLE:    pin_on     = cfg_wdata[0];
                    default: ;
                endcase
            end

            // A report beat is always for a tick taken at an earlier edge.
            if (out_valid && out_ready)
            begin
                if (report_q.size() == 0)
                begin
                    $error("report beat arrived with no tick outstanding");
                    mismatches++;
                end
                else
                begin
                    want = report_q.pop_front();
                    check_field("tip_confirmed", 32'(want.confirmed), 32'(tip_confirmed));
                    check_field("tip_rejected", 32'(want.rejected), 32'(tip_rejected));
                    check_field("minute_valid", 32'(want.minute_closed), 32'(minute_valid));
                    check_field("minute_tips", 32'(want.minute_total), 32'(minute_tips));
                    check_field("day_tips", want.day_total, day_tips);
                    check_field("since_tips", want.since_total, since_tips);
                end
            end

            if (in_valid && in_ready)
                report_q.push_back(predict_tick(pin_level, clear_day, take_since));

            fail_count  <= mismatches;
            reports_due <= report_q.size();
        end
    end

endmodule

@@ bench/tb_rain_tip_debounce_counter_unit.sv @@
// Top of the rain tip debounce counter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_rain_tip_debounce_counter_unit;
    import rtdc_pkg::*;

    localparam int CYCLE_LIMIT   = 20_000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_TICKS   = 62;

    logic                  clk;
    logic                  rst_n      = 1'b0;
    logic                  cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr   = CFG_REPEAT_WINDOW;
    logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic                  pin_level  = 1'b1;
    logic                  clear_day  = 1'b0;
    logic                  take_since = 1'b0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic                  tip_confirmed;
    logic                  tip_rejected;
    logic                  minute_valid;
    logic [MINUTE_W-1:0]   minute_tips;
    logic [COUNT_W-1:0]    day_tips;
    logic [COUNT_W-1:0]    since_tips;
    int                    fail_count;
    int                    reports_due;

    logic idle_on = 1'b1;
    int   cycle_count = 0;

    rain_tip_debounce_counter_unit dut (.*);
    rtdc_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Report side stalls at random unless idling is switched off.
    always @(posedge clk)
        out_ready <= !idle_on || ($urandom_range(0, 99) >= 22);

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Send one tick beat, with random gaps in front of it.
    task automatic send_tick(input logic lvl, input logic clr_day, input logic take);
        while (idle_on && $urandom_range(0, 99) < 22)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        pin_level  <= lvl;
        clear_day  <= clr_day;
        take_since <= take;
        do @(posedge clk); while (!in_ready);
    endtask

    // Hold the tick channel until every report has come back.
    task automatic wait_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (reports_due != 0);
    endtask

    // Write all four registers on consecutive cycles; the block is idle.
    task automatic set_config(input logic [WIN_W-1:0] rep_ms, input logic [WIN_W-1:0] glitch_ms,
                              input logic [TIME_W-1:0] period_ms, input logic enable);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_REPEAT_WINDOW;
        cfg_wdata <= CFG_DATA_W'(rep_ms);
        @(posedge clk);
        cfg_addr  <= CFG_GLITCH_WINDOW;
        cfg_wdata <= CFG_DATA_W'(glitch_ms);
        @(posedge clk);
        cfg_addr  <= CFG_MINUTE_PERIOD;
        cfg_wdata <= CFG_DATA_W'(period_ms);
        @(posedge clk);
        cfg_addr  <= CFG_PIN_ENABLE;
        cfg_wdata <= CFG_DATA_W'(enable);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        logic [WIN_W-1:0]  rep_ms;
        logic [WIN_W-1:0]  glitch_ms;
        logic [TIME_W-1:0] period_ms;
        logic              enable;
        logic              pin_now;
        int                run_left;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: an edge inside the repeat window is ignored; flags on zero counts.
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1);

        // No windows and a zero period: a tip confirms on its own tick, every tick closes.
        wait_drain();
        set_config('0, '0, '0, 1'b1);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b1);
        send_tick(1'b1, 1'b0, 1'b0);

        // Glitch window of two: a bounce is rejected, a held closure is confirmed.
        wait_drain();
        set_config('0, 16'd2, 32'd3, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);

        // Pin disabled with a candidate open: no new edges, the candidate waits.
        wait_drain();
        set_config('0, 16'd2, 32'd3, 1'b0);
        send_tick(1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b0);

        // Enabled again: the waiting candidate is decided at once.
        wait_drain();
        set_config('0, 16'd2, 32'd3, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);

        // Random phases: switch-like pulses with bounces and noise under varied settings.
        pin_now  = 1'b1;
        run_left = 0;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drain();
            case ($urandom_range(0, 3))
                0: rep_ms = '0;
                1: rep_ms = '1;
                2: rep_ms = WIN_W'($urandom_range(1, 6));
                default: rep_ms = WIN_W'($urandom_range(7, 40));
            endcase
            case ($urandom_range(0, 3))
                0: glitch_ms = '0;
                1: glitch_ms = '1;
                2: glitch_ms = WIN_W'($urandom_range(1, 4));
                default: glitch_ms = WIN_W'($urandom_range(5, 15));
            endcase
            case ($urandom_range(0, 4))
                0: period_ms = 32'd1;
                1: period_ms = '1;
                2: period_ms = '0;
                default: period_ms = TIME_W'($urandom_range(2, 50));
            endcase
            enable = ($urandom_range(0, 4) != 0);

            // Pin the extremes to known phases so each run sees them.
            if (phase == 0)
            begin
                rep_ms    = '0;
                glitch_ms = '0;
                period_ms = 32'd1;
                enable    = 1'b1;
            end
            else if (phase == 1)
            begin
                rep_ms    = '1;
                glitch_ms = '1;
                period_ms = '1;
            end
            else if (phase == 2)
            begin
                enable = 1'b0;
            end
            set_config(rep_ms, glitch_ms, period_ms, enable);

            idle_on = (phase != 4);
            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                if (run_left == 0)
                begin
                    pin_now  = ~pin_now;
                    run_left = pin_now ? $urandom_range(1, 8)
                             : (($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 12));
                end
                run_left--;
                send_tick(($urandom_range(0, 19) == 0) ? ~pin_now : pin_now,
                          ($urandom_range(0, 19) == 0), ($urandom_range(0, 11) == 0));
            end
        end

        // A one tick period closes a minute on every tick while the flags toggle.
        wait_drain();
        idle_on = 1'b1;
        set_config('0, '0, 32'd1, 1'b1);
        for (int n = 0; n < 12; n++)
            send_tick(1'b1, n[0], n[1]);

        wait_drain();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
